[rtl/v3n_pkg.sv]
// ----------------------------------------------------------------------------
// v3n_pkg
// shared constants of the vector normalizer
// ----------------------------------------------------------------------------
package v3n_pkg;
	localparam int FRAC_SHIFT = 30;
	localparam int MINLEN_W   = 17;
	localparam int FIELD_W    = 32;
	localparam logic [MINLEN_W-1:0] MINLEN_RESET = 17'd1;
endpackage

[rtl/v3n_in_if.sv]
// ----------------------------------------------------------------------------
// v3n_in_if
// input vector channel
// ----------------------------------------------------------------------------
interface v3n_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] in_x;
	logic [31:0] in_y;
	logic [31:0] in_z;
	modport source (output valid, in_x, in_y, in_z, input ready);
	modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

[rtl/v3n_out_if.sv]
// ----------------------------------------------------------------------------
// v3n_out_if
// result channel
// ----------------------------------------------------------------------------
interface v3n_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] length;
	logic [31:0] dir_x;
	logic [31:0] dir_y;
	logic [31:0] dir_z;
	logic        degenerate;
	modport source (output valid, length, dir_x, dir_y, dir_z, degenerate, input ready);
	modport sink   (input valid, length, dir_x, dir_y, dir_z, degenerate, output ready);
endinterface

[rtl/v3n_cfg_if.sv]
// ----------------------------------------------------------------------------
// v3n_cfg_if
// configuration write channel
// ----------------------------------------------------------------------------
interface v3n_cfg_if;
	logic        valid;
	logic        ready;
	logic [16:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

[rtl/v3n_front.sv]
// ----------------------------------------------------------------------------
// v3n_front
// sign split, squares and square root pipeline: one root bit per stage
// ----------------------------------------------------------------------------
module v3n_front #(
	parameter int CW = 32,
	parameter int LW = CW + 1,
	parameter int SW = 2 * CW + 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [CW-1:0] in_a [3],
	input  logic          stall,
	output logic          out_vld,
	output logic [LW-1:0] out_len,
	output logic [CW-1:0] out_mag [3],
	output logic [2:0]    out_neg
);
	localparam int NS = LW + 2;

	// stage 0: magnitudes, stage 1: squares, stage 2: sum, then LW root stages
	logic          vld_s [NS+1];
	logic [CW-1:0] mag_s [NS+1][3];
	logic [2:0]    neg_s [NS+1];
	logic [SW-1:0] sq_s1 [3];
	logic [SW-1:0] rem_s [NS+1];
	logic [LW-1:0] root_s [NS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NS; i++) vld_s[i] <= 1'b0;
		end else if (!stall) begin
			vld_s[0] <= in_vld;
			for (int i = 1; i <= NS; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			for (int k = 0; k < 3; k++) begin
				neg_s[0][k] <= in_a[k][CW-1];
				mag_s[0][k] <= in_a[k][CW-1] ? (~in_a[k] + CW'(1)) : in_a[k];
				sq_s1[k] <= SW'(mag_s[0][k] * mag_s[0][k]);
			end
			mag_s[1] <= mag_s[0];
			neg_s[1] <= neg_s[0];
			rem_s[2] <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			root_s[2] <= '0;
			mag_s[2] <= mag_s[1];
			neg_s[2] <= neg_s[1];
			for (int i = 3; i <= NS; i++) begin
				mag_s[i] <= mag_s[i-1];
				neg_s[i] <= neg_s[i-1];
			end
		end
	end

	// restoring root: stage for bit b compares (2r + bit)*bit weight
	for (genvar g = 0; g < LW; g++) begin : g_root
		localparam int B = LW - 1 - g;
		logic [SW+1:0] trial;
		assign trial = ({{(SW+2-LW){1'b0}}, root_s[g+2]} << (B + 1)) + ((SW+2)'(1) << (2 * B));
		always_ff @(posedge clk) begin
			if (!stall) begin
				if (trial <= {2'b00, rem_s[g+2]}) begin
					rem_s[g+3]  <= SW'({2'b00, rem_s[g+2]} - trial);
					root_s[g+3] <= root_s[g+2] | (LW'(1) << B);
				end else begin
					rem_s[g+3]  <= rem_s[g+2];
					root_s[g+3] <= root_s[g+2];
				end
			end
		end
	end

	assign out_vld = vld_s[NS];
	assign out_len = root_s[NS];
	assign out_mag = mag_s[NS];
	assign out_neg = neg_s[NS];
endmodule

[rtl/v3n_queue.sv]
// ----------------------------------------------------------------------------
// v3n_queue
// small fifo between front and back parts
// ----------------------------------------------------------------------------
module v3n_queue #(
	parameter int W = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [W-1:0] wr_data,
	input  logic         rd_en,
	output logic [W-1:0] rd_data,
	output logic         not_empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int AW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);
	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [NW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (rd_en) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + NW'(wr_en) - NW'(rd_en);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	assign rd_data   = mem_q[rp_q];
	assign not_empty = cnt_q != '0;
	assign count     = cnt_q;
endmodule

[rtl/v3n_back.sv]
// ----------------------------------------------------------------------------
// v3n_back
// degenerate check and three pipelined restoring dividers, one bit per stage
// ----------------------------------------------------------------------------
module v3n_back
	import v3n_pkg::*;
#(
	parameter int CW = 32,
	parameter int LW = CW + 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                stall,
	input  logic                in_vld,
	input  logic [LW-1:0]       in_len,
	input  logic [CW-1:0]       in_mag [3],
	input  logic [2:0]          in_neg,
	input  logic [MINLEN_W-1:0] min_len,
	output logic                out_vld,
	output logic [31:0]         out_len,
	output logic [31:0]         out_dir [3],
	output logic                out_deg
);
	localparam int NQ = FRAC_SHIFT + 1;
	localparam int NW = CW + FRAC_SHIFT;
	localparam int DW = LW + 1;

	logic          vld_s [NQ+2];
	logic          deg_s [NQ+2];
	logic [LW-1:0] len_s [NQ+2];
	logic [2:0]    neg_s [NQ+2];
	logic [DW-1:0] rem_s [NQ+2][3];
	logic [NW-1:0] num_s [NQ+2][3];
	logic [NQ-1:0] quo_s [NQ+1][3];
	logic [31:0]   dir_s [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= NQ + 1; i++) vld_s[i] <= 1'b0;
		end else if (!stall) begin
			vld_s[0] <= in_vld;
			for (int i = 1; i <= NQ + 1; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			deg_s[0] <= (in_len == '0) || (in_len < LW'(min_len));
			len_s[0] <= in_len;
			neg_s[0] <= in_neg;
			for (int k = 0; k < 3; k++) begin
				num_s[0][k] <= {in_mag[k], {FRAC_SHIFT{1'b0}}};
				rem_s[0][k] <= '0;
				quo_s[0][k] <= '0;
			end
			for (int i = 1; i <= NQ + 1; i++) begin
				deg_s[i] <= deg_s[i-1];
				len_s[i] <= len_s[i-1];
				neg_s[i] <= neg_s[i-1];
			end
		end
	end

	// division: first skip the high numerator bits the quotient never reaches
	// (mag <= len so quotient < 2^(FRAC_SHIFT+1)); stage 0 preloads them
	for (genvar g = 0; g < NQ; g++) begin : g_div
		for (genvar k = 0; k < 3; k++) begin : g_lane
			logic [DW:0]   pre;
			logic [DW:0]   dif;
			logic [DW-1:0] start;
			if (g == 0) begin : g_first
				assign start = DW'(num_s[0][k][NW-1:NQ-1] >> 1);
				assign pre = {start, num_s[0][k][NQ-1]};
			end else begin : g_next
				assign start = rem_s[g][k];
				assign pre = {start, num_s[g][k][NQ-1-g]};
			end
			assign dif = pre - {2'b00, len_s[g]};
			always_ff @(posedge clk) begin
				if (!stall) begin
					num_s[g+1][k] <= num_s[g][k];
					if (!dif[DW]) begin
						rem_s[g+1][k] <= DW'(dif);
						quo_s[g+1][k] <= quo_s[g][k] | (NQ'(1) << (NQ - 1 - g));
					end else begin
						rem_s[g+1][k] <= DW'(pre);
						quo_s[g+1][k] <= quo_s[g][k];
					end
				end
			end
		end
	end

	// sign applied at full output width so a quotient of exactly one stays positive
	always_ff @(posedge clk) begin
		if (!stall) begin
			for (int k = 0; k < 3; k++) begin
				if (deg_s[NQ])
					dir_s[k] <= '0;
				else if (neg_s[NQ][k])
					dir_s[k] <= ~(32'(quo_s[NQ][k])) + 32'd1;
				else
					dir_s[k] <= 32'(quo_s[NQ][k]);
			end
		end
	end

	assign out_vld = vld_s[NQ+1];
	assign out_deg = deg_s[NQ+1];
	always_comb begin
		if (deg_s[NQ+1])
			out_len = '0;
		else if (LW > 32 && (len_s[NQ+1] >> 32) != '0)
			out_len = '1;
		else
			out_len = 32'(len_s[NQ+1]);
		for (int k = 0; k < 3; k++) begin
			out_dir[k] = dir_s[k];
		end
	end
endmodule

[rtl/vector3_normalize.sv]
// ----------------------------------------------------------------------------
// vector3_normalize
// length and unit direction of a signed q16.16 3-d vector
// ----------------------------------------------------------------------------
// channel | dir | handshake   | payload
// cfg     | in  | valid/ready | data (min_length, 17 bits)
// vin     | in  | valid/ready | in_x, in_y, in_z
// vout    | out | valid/ready | length, dir_x, dir_y, dir_z, degenerate
//
// one vector per cycle while neither pipeline stalls; a root pipeline, then the
// queue, then a divider pipeline with one quotient bit a stage
// arst_n clears valid bits, queue pointers and min_length (to 1)
// the front pipeline stalls as a whole, refusing input, while its last stage
// holds a vector and the queue is full; the back pipeline stalls as a whole
// while the output transaction is refused
// ----------------------------------------------------------------------------
module vector3_normalize
	import v3n_pkg::*;
#(
	parameter int COMP_WIDTH = 32
) (
	input logic   clk,
	input logic   arst_n,
	v3n_cfg_if.sink  cfg,
	v3n_in_if.sink   vin,
	v3n_out_if.source vout
);
	localparam int CW = COMP_WIDTH;
	localparam int LW = CW + 1;
	localparam int QDEPTH = 4;               // short queue between front and back
	localparam int QW = LW + 3 * CW + 3;
	localparam int CNTW = $clog2(QDEPTH + 1);

	logic [MINLEN_W-1:0] min_len_q;
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) min_len_q <= MINLEN_RESET;
		else if (cfg.valid) min_len_q <= cfg.data;
	end

	// front holds while its output cannot enter the queue
	logic          in_acc;
	logic [CW-1:0] in_a [3];
	logic          f_vld;
	logic          f_stall;
	logic [LW-1:0] f_len;
	logic [CW-1:0] f_mag [3];
	logic [2:0]    f_neg;
	logic [CNTW-1:0] q_cnt;
	logic          q_wr;

	assign in_a[0] = CW'(vin.in_x);
	assign in_a[1] = CW'(vin.in_y);
	assign in_a[2] = CW'(vin.in_z);
	assign f_stall = f_vld && (q_cnt == CNTW'(QDEPTH));
	assign vin.ready = !f_stall;
	assign in_acc = vin.valid && vin.ready;
	assign q_wr = f_vld && !f_stall;

	v3n_front #(.CW(CW), .LW(LW)) u_front (
		.clk, .arst_n, .in_vld(in_acc), .in_a, .stall(f_stall),
		.out_vld(f_vld), .out_len(f_len), .out_mag(f_mag), .out_neg(f_neg)
	);

	logic [QW-1:0] q_wd, q_rd;
	logic          q_ne, q_rd_en, b_stall;
	assign q_wd = {f_len, f_mag[0], f_mag[1], f_mag[2], f_neg};

	v3n_queue #(.W(QW), .DEPTH(QDEPTH)) u_queue (
		.clk, .arst_n, .wr_en(q_wr), .wr_data(q_wd), .rd_en(q_rd_en),
		.rd_data(q_rd), .not_empty(q_ne), .count(q_cnt)
	);

	logic [LW-1:0] b_len;
	logic [CW-1:0] b_mag [3];
	logic [2:0]    b_neg;
	logic          o_vld, o_deg;
	logic [31:0]   o_len;
	logic [31:0]   o_dir [3];

	assign {b_len, b_mag[0], b_mag[1], b_mag[2], b_neg} = q_rd;
	assign b_stall = vout.valid && !vout.ready;
	assign q_rd_en = q_ne && !b_stall;

	v3n_back #(.CW(CW), .LW(LW)) u_back (
		.clk, .arst_n, .stall(b_stall), .in_vld(q_rd_en), .in_len(b_len),
		.in_mag(b_mag), .in_neg(b_neg), .min_len(min_len_q),
		.out_vld(o_vld), .out_len(o_len), .out_dir(o_dir), .out_deg(o_deg)
	);

	assign vout.valid      = o_vld;
	assign vout.length     = o_len;
	assign vout.dir_x      = o_dir[0];
	assign vout.dir_y      = o_dir[1];
	assign vout.dir_z      = o_dir[2];
	assign vout.degenerate = o_deg;

`ifndef SYNTH
	// queue must never be written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_wr && q_cnt == CNTW'(QDEPTH))) else $error("queue overflow");
	// input is refused only while the queue is full
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!vin.ready |-> q_cnt == CNTW'(QDEPTH)) else $error("input refused early");
	// degenerate results carry zero length
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vout.valid && vout.degenerate |-> vout.length == '0) else $error("deg length");
`endif
endmodule

[tb/sv/tb_vector3_normalize.sv]
// ----------------------------------------------------------------------------
// tb_vector3_normalize
// self-checking bench: a scoreboard predicts length, direction and the
// degenerate flag of each accepted vector and checks every result in order
// ----------------------------------------------------------------------------
module tb_vector3_normalize
	import v3n_pkg::*;
();

	localparam int COMP_W   = 32;
	localparam int LATENCY  = COMP_W + 3 + 1 + 33 + 8;
	localparam int WD_LIMIT = 20000;

	typedef struct packed {
		logic [31:0] length;
		logic [31:0] dir_x;
		logic [31:0] dir_y;
		logic [31:0] dir_z;
		logic        degenerate;
	} unit_vec_t;

	// scoreboard: predicts the normalized vector and holds pending results
	class norm_scoreboard;
		unit_vec_t              pending[$];
		logic [MINLEN_W-1:0]    min_len;
		int                     errors;

		function new();
			min_len = MINLEN_RESET;
			errors  = 0;
		endfunction

		function logic [63:0] root_floor(logic [65:0] s);
			logic [63:0]  r;
			logic [63:0]  c;
			r = 0;
			for (int b = 63; b >= 0; b--) begin
				c = r | (64'd1 << b);
				if ({64'd0, c} * {64'd0, c} <= {62'd0, s}) r = c;
			end
			return r;
		endfunction

		function void note_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
			logic [31:0]  comp[3];
			logic [31:0]  mag[3];
			logic         neg[3];
			logic [65:0]  sum;
			logic [63:0]  len;
			logic [95:0]  q;
			unit_vec_t    e;
			comp[0] = x; comp[1] = y; comp[2] = z;
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				neg[i] = comp[i][31];
				mag[i] = neg[i] ? -comp[i] : comp[i];
				sum += {34'd0, mag[i]} * {34'd0, mag[i]};
			end
			len = root_floor(sum);
			e = '0;
			if (len == 0 || len < {47'd0, min_len}) begin
				e.degenerate = 1'b1;
			end else begin
				e.length = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
				for (int i = 0; i < 3; i++) begin
					q = ({64'd0, mag[i]} << FRAC_SHIFT) / {32'd0, len};
					if (neg[i]) q = -q;
					case (i)
						0: e.dir_x = q[31:0];
						1: e.dir_y = q[31:0];
						default: e.dir_z = q[31:0];
					endcase
				end
			end
			pending.push_back(e);
		endfunction

		function void check_result(unit_vec_t got);
			unit_vec_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.length !== e.length) begin
				$display("%0t length: expected %h actual %h", $time, e.length, got.length);
				errors++;
			end
			if (got.dir_x !== e.dir_x) begin
				$display("%0t dir_x: expected %h actual %h", $time, e.dir_x, got.dir_x);
				errors++;
			end
			if (got.dir_y !== e.dir_y) begin
				$display("%0t dir_y: expected %h actual %h", $time, e.dir_y, got.dir_y);
				errors++;
			end
			if (got.dir_z !== e.dir_z) begin
				$display("%0t dir_z: expected %h actual %h", $time, e.dir_z, got.dir_z);
				errors++;
			end
			if (got.degenerate !== e.degenerate) begin
				$display("%0t degenerate: expected %b actual %b", $time, e.degenerate,
					got.degenerate);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	v3n_cfg_if cfg ();
	v3n_in_if  vin ();
	v3n_out_if vout ();

	vector3_normalize #(.COMP_WIDTH(COMP_W)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg.sink),
		.vin    (vin.sink),
		.vout   (vout.source)
	);

	norm_scoreboard sb;

	// idle percentages, changed per phase
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	bit          recv_hold;
	int          watchdog;

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// receiver: random stalls, long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout.ready <= 1'b0;
		end else begin
			vout.ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result monitor, sampled at the edge
	always @(posedge clk) begin
		if (arst_n && vout.valid && vout.ready)
			sb.check_result({vout.length, vout.dir_x, vout.dir_y, vout.dir_z,
				vout.degenerate});
	end

	// input monitor: prediction uses the register value in effect
	always @(posedge clk) begin
		if (arst_n && vin.valid && vin.ready) sb.note_vector(vin.in_x, vin.in_y, vin.in_z);
		if (arst_n && cfg.valid && cfg.ready) sb.min_len = cfg.data;
	end

	// watchdog: cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((vin.valid && vin.ready) || (vout.valid && vout.ready)
				|| (cfg.valid && cfg.ready))
			watchdog <= 0;
		else
			watchdog <= watchdog + 1;
		if (watchdog >= WD_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// one vector transaction, holding valid until accepted
	task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			vin.valid <= 1'b0;
			@(posedge clk);
		end
		vin.valid <= 1'b1;
		vin.in_x  <= x;
		vin.in_y  <= y;
		vin.in_z  <= z;
		@(posedge clk);
		while (!vin.ready) @(posedge clk);
	endtask

	task automatic idle_input();
		vin.valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for the pipeline to drain, then let it settle
	task automatic drain();
		idle_input();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	// register write, only with the block idle
	task automatic write_min_length(logic [MINLEN_W-1:0] v);
		drain();
		cfg.valid <= 1'b1;
		cfg.data  <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// random component: mostly moderate, sometimes full range or tiny
	function automatic logic [31:0] rand_comp();
		case ($urandom_range(5))
			0: return $urandom;
			1: return $urandom_range(255) - 128;
			2: return {{16{1'b0}}, 16'($urandom)} ^ ({32{$urandom_range(1) == 1}});
			3: return ($urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
			default: return $signed($urandom) >>> $urandom_range(31);
		endcase
	endfunction

	task automatic random_batch(int n);
		for (int i = 0; i < n; i++) send_vector(rand_comp(), rand_comp(), rand_comp());
	endtask

	initial begin
		sb = new();
		arst_n         = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		recv_hold      = 1'b0;
		watchdog       = 0;
		vin.valid      = 1'b0;
		vin.in_x       = '0;
		vin.in_y       = '0;
		vin.in_z       = '0;
		cfg.valid      = 1'b0;
		cfg.data       = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (LATENCY) @(posedge clk);

		// directed: zero vector with reset minimum, extremes and axes
		send_vector(32'd0, 32'd0, 32'd0);
		send_vector(32'd1, 32'd0, 32'd0);
		send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vector(32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
		send_vector(32'hFFFF_FFFF, 32'd0, 32'd0);
		send_vector(32'd0, 32'h0001_0000, 32'd0);
		send_vector(32'd0, 32'd0, 32'hFFFF_0000);
		send_vector(32'd3, 32'd4, 32'd0);
		send_vector(32'hFFFF_FFFD, 32'hFFFF_FFFC, 32'd12);
		send_vector(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);

		// zero length with a zero minimum is still degenerate
		write_min_length('0);
		send_vector(32'd0, 32'd0, 32'd0);
		send_vector(32'd1, 32'd1, 32'd1);

		// largest minimum, just under two, then a threshold right at one
		write_min_length(17'h1FFFF);
		send_vector(32'h0001_0000, 32'd0, 32'd0);
		send_vector(32'h0001_FFFF, 32'd0, 32'd0);
		send_vector(32'h0002_0000, 32'd0, 32'd0);
		write_min_length(17'd65536);
		send_vector(32'h0000_FFFF, 32'd0, 32'd0);
		send_vector(32'h0001_0000, 32'd0, 32'd0);
		send_vector(32'h0000_B505, 32'h0000_B505, 32'd0);

		// random phases across settings and idling patterns
		write_min_length(17'd1);
		random_batch(150);
		send_idle_pct = 67;
		write_min_length(MINLEN_W'($urandom_range(65536)));
		random_batch(150);
		send_idle_pct  = 0;
		recv_stall_pct = 67;
		write_min_length(MINLEN_W'($urandom_range(4095)));
		random_batch(150);
		send_idle_pct  = 6;
		recv_stall_pct = 6;
		write_min_length(17'h1FFFF);
		random_batch(100);

		// long receiver hold-off while the sender keeps offering
		write_min_length(17'd0);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		fork
			begin
				recv_hold = 1'b1;
				repeat (300) @(posedge clk);
				recv_hold = 1'b0;
			end
			random_batch(150);
		join
		// sender pauses until everything has come back
		drain();
		send_idle_pct = 67;
		recv_stall_pct = 67;
		write_min_length(MINLEN_W'($urandom_range(65536)));
		random_batch(150);

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

[vector3_normalize.f]
rtl/v3n_pkg.sv
rtl/v3n_in_if.sv
rtl/v3n_out_if.sv
rtl/v3n_cfg_if.sv
rtl/v3n_front.sv
rtl/v3n_queue.sv
rtl/v3n_back.sv
rtl/vector3_normalize.sv
tb/sv/tb_vector3_normalize.sv
